[hdl/tga_pixel_stream_decoder_defines.svh]
// ----------------------------------------------------------------------------
// TGA pixel stream decoder: assertion macros
// Shared concurrent assertion forms, clocked on aclk, off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef TGA_PIXEL_STREAM_DECODER_DEFINES_SVH
`define TGA_PIXEL_STREAM_DECODER_DEFINES_SVH

// property must hold at every clock edge out of reset
`define TPD_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition must never be true at a clock edge out of reset
`define TPD_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

[hdl/tpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder: package
// Shared types, constants and color decode functions.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = OUT_PW + 1;

    localparam logic [2:0] CFG_COMPRESSED      = 3'd0;
    localparam logic [2:0] CFG_COLOR_MAPPED    = 3'd1;
    localparam logic [2:0] CFG_PIXEL_BYTES     = 3'd2;
    localparam logic [2:0] CFG_PIXEL_COUNT     = 3'd3;
    localparam logic [2:0] CFG_PALETTE_LENGTH  = 3'd4;
    localparam logic [2:0] CFG_PAL_ENTRY_BYTES = 3'd5;

    localparam logic [31:0] BLACK      = 32'hFF00_0000;
    localparam logic [28:0] MAX_PIXELS = 29'h1000_0000;
    localparam logic [7:0]  LEN_MASK   = 8'h7F;

    typedef struct packed {
        logic        compressed;
        logic        color_mapped;
        logic [2:0]  pixel_bytes;
        logic [28:0] pixel_count;
        logic [8:0]  palette_length;
        logic [2:0]  palette_entry_bytes;
    } cfg_t;

    typedef struct packed {
        logic [31:0] color_argb;
        logic [7:0]  run_length;
        logic [27:0] first_pixel;
        logic        image_last;
        logic        truncated;
    } result_t;

    typedef struct packed {
        logic a_valid;
        logic b_valid;
    } push_t;

    function automatic logic [2:0] clamp_bytes(input logic [2:0] v);
        if (v == 3'd0) begin
            return 3'd1;
        end else if (v > 3'd4) begin
            return 3'd4;
        end
        return v;
    endfunction

    function automatic logic [7:0] rep5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [31:0] decode_color(input logic [31:0] rec,
                                                 input logic [2:0]  n);
        logic [31:0] c;
        case (n)
            3'd1: begin
                c = {8'hFF, rec[7:0], rec[7:0], rec[7:0]};
            end
            3'd2: begin
                c = {8'hFF, rep5(rec[14:10]), rep5(rec[9:5]), rep5(rec[4:0])};
            end
            3'd3: begin
                c = {8'hFF, rec[23:0]};
            end
            default: begin
                c = rec;
            end
        endcase
        return c;
    endfunction

endpackage

[hdl/tga_pixel_stream_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder
// Takes the TGA file bytes after the header and ID field, one byte per beat,
// fills the palette store from the color map and then turns raw or RLE pixel
// records into ARGB runs tagged with their file-order pixel index. A byte can
// be accepted every cycle while s_ready is high. Each result is registered in
// the result stage and then written to a four-beat result queue, which offers
// it on the output channel. A byte that ends the stream before the image is
// complete yields a pixel beat (if it finishes one) and a truncation status
// beat. Input stalls whenever the queue plus the result stage hold more than
// two beats: while the result side is held, and after a byte that yields two
// beats, since the queue drains at most one beat per cycle.
// The palette lookup uses one registered read port of the palette memory.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder import tpd_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [28:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_stream_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_color_argb,
    output logic [7:0]  m_run_length,
    output logic [27:0] m_first_pixel,
    output logic        m_image_last,
    output logic        m_truncated
);

    cfg_t              cfg_reg;
    logic              s_accept;
    push_t             push;
    result_t           item_a, item_b, m_item;
    logic [1:0]        pend_n;
    logic [OUT_CW-1:0] fifo_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{compressed: 1'b0, color_mapped: 1'b0, pixel_bytes: 3'd4,
                         pixel_count: 29'd1, palette_length: 9'd0,
                         palette_entry_bytes: 3'd3};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COMPRESSED:      cfg_reg.compressed          <= cfg_wr_data[0];
                CFG_COLOR_MAPPED:    cfg_reg.color_mapped        <= cfg_wr_data[0];
                CFG_PIXEL_BYTES:     cfg_reg.pixel_bytes         <= cfg_wr_data[2:0];
                CFG_PIXEL_COUNT:     cfg_reg.pixel_count         <= cfg_wr_data;
                CFG_PALETTE_LENGTH:  cfg_reg.palette_length      <= cfg_wr_data[8:0];
                CFG_PAL_ENTRY_BYTES: cfg_reg.palette_entry_bytes <= cfg_wr_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // hold input unless the queue has room for everything in flight plus two
    assign s_ready  = ({1'b0, fifo_count} + (OUT_CW + 1)'(pend_n))
                      <= (OUT_CW + 1)'(OUT_DEPTH - 2);
    assign s_accept = s_valid && s_ready;

    tpd_parser #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_accept   (s_accept),
        .data_byte  (s_data_byte),
        .stream_end (s_stream_end),
        .push       (push),
        .item_a     (item_a),
        .item_b     (item_b),
        .pend_n     (pend_n)
    );

    tpd_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .item_a  (item_a),
        .item_b  (item_b),
        .count   (fifo_count),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    assign m_color_argb  = m_item.color_argb;
    assign m_run_length  = m_item.run_length;
    assign m_first_pixel = m_item.first_pixel;
    assign m_image_last  = m_item.image_last;
    assign m_truncated   = m_item.truncated;

endmodule

[hdl/tpd_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder: result queue
// Small register queue that takes up to two result beats per cycle and
// presents one beat per cycle on the output channel while m_ready is high.
// ----------------------------------------------------------------------------
module tpd_out_fifo import tpd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  push_t              push,
    input  result_t            item_a,
    input  result_t            item_b,
    output logic [OUT_CW-1:0]  count,
    output logic               m_valid,
    input  logic               m_ready,
    output result_t            m_item
);
`include "tga_pixel_stream_decoder_defines.svh"

    result_t             q_mem [OUT_DEPTH];
    logic [OUT_PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CW-1:0]   count_reg, count_next;
    logic [1:0]          push_n;
    logic                pop;
    logic                overfill;

    assign pop     = m_valid && m_ready;
    assign push_n  = {1'b0, push.a_valid} + {1'b0, push.b_valid};
    assign m_valid = (count_reg != '0);
    assign m_item  = q_mem[rd_ptr_reg];
    assign count   = count_reg;

    assign overfill = ({1'b0, count_reg} + {{(OUT_CW - 1){1'b0}}, push_n})
                      > ({1'b0, OUT_CW'(OUT_DEPTH)} + {{OUT_CW{1'b0}}, pop});

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUT_PW'(push_n);
        rd_ptr_next = rd_ptr_reg + OUT_PW'(pop);
        count_next  = count_reg + OUT_CW'(push_n) - OUT_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.a_valid) begin
            q_mem[wr_ptr_reg] <= item_a;
        end
        if (push.b_valid) begin
            q_mem[wr_ptr_reg + OUT_PW'(1)] <= item_b;
        end
    end

    `TPD_ASSERT_NEVER(a_fifo_overfill, overfill, "result queue overflow")
    `TPD_ASSERT_NEVER(a_fifo_b_alone, push.b_valid && !push.a_valid, "second beat without first")

endmodule

[hdl/tpd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder: byte parser
// Per-byte state update for palette and pixel records, RLE packets, palette
// store and one result stage with the registered palette read.
// ----------------------------------------------------------------------------
module tpd_parser import tpd_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_accept,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    output push_t       push,
    output result_t     item_a,
    output result_t     item_b,
    output logic [1:0]  pend_n
);
`include "tga_pixel_stream_decoder_defines.svh"

    localparam int AW = $clog2(PALETTE_DEPTH);

    localparam logic [1:0] PH_PALETTE = 2'd0;
    localparam logic [1:0] PH_PIXELS  = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    logic [31:0] pal_mem [PALETTE_DEPTH];

    logic [1:0]  phase_reg, phase_next;
    logic [8:0]  fill_reg, fill_next;
    logic [1:0]  bir_reg, bir_next;
    logic [23:0] held_reg, held_next;
    logic [7:0]  left_reg, left_next;
    logic        run_reg, run_next;
    logic [28:0] done_reg, done_next;

    logic        p_a_valid_reg, p_b_valid_reg;
    logic [31:0] p_color_reg;
    logic [7:0]  p_len_reg;
    logic [27:0] p_first_reg;
    logic        p_last_reg;
    logic        p_use_pal_reg;
    logic        p_hit_reg;
    logic [27:0] p_stat_first_reg;
    logic [31:0] pal_q_reg;

    logic [2:0]  pb, eb;
    logic [28:0] pc, remaining;
    logic [1:0]  phase_e, bir_e;
    logic [23:0] held_e;
    logic [31:0] rec;
    logic [15:0] idx;
    logic        hit;
    logic        a_valid, b_valid, last;
    logic [7:0]  len;
    logic [27:0] stat_first;
    logic        pal_we;
    logic [31:0] pal_wdata, dec;
    logic [16:0] wr_addr_ext, rd_addr_ext;
    logic [31:0] color_a;
    result_t     pix_item, stat_item;

    always_comb begin
        pb = clamp_bytes(cfg.pixel_bytes);
        eb = clamp_bytes(cfg.palette_entry_bytes);
        if (cfg.pixel_count == '0) begin
            pc = 29'd1;
        end else if (cfg.pixel_count > MAX_PIXELS) begin
            pc = MAX_PIXELS;
        end else begin
            pc = cfg.pixel_count;
        end

        phase_e = phase_reg;
        bir_e   = bir_reg;
        held_e  = held_reg;
        if (phase_reg == PH_PALETTE && fill_reg >= cfg.palette_length) begin
            phase_e = PH_PIXELS;
            bir_e   = 2'd0;
            held_e  = 24'd0;
        end

        rec       = {8'h00, held_e} | ({24'h000000, data_byte} << {bir_e, 3'b000});
        remaining = pc - done_reg;
        idx       = (pb == 3'd1) ? {8'h00, rec[7:0]} : rec[15:0];
        hit       = (17'(idx) < 17'(fill_reg)) && (17'(idx) < 17'(PALETTE_DEPTH));
        dec       = decode_color(rec, pb);
        pal_wdata = decode_color(rec, eb);

        phase_next = phase_e;
        bir_next   = bir_e;
        held_next  = held_e;
        fill_next  = fill_reg;
        left_next  = left_reg;
        run_next   = run_reg;
        done_next  = done_reg;
        a_valid    = 1'b0;
        len        = 8'd1;
        last       = 1'b0;
        pal_we     = 1'b0;

        case (phase_e)
            PH_PALETTE: begin
                if (({1'b0, bir_e} + 3'd1) >= eb) begin
                    pal_we    = 17'(fill_reg) < 17'(PALETTE_DEPTH);
                    fill_next = fill_reg + 9'd1;
                    bir_next  = 2'd0;
                    held_next = 24'd0;
                    if (fill_next >= cfg.palette_length) begin
                        phase_next = PH_PIXELS;
                    end
                end else begin
                    held_next = rec[23:0];
                    bir_next  = bir_e + 2'd1;
                end
            end
            PH_PIXELS: begin
                if (done_reg >= pc) begin
                    phase_next = PH_DONE;
                end else if (cfg.compressed && left_reg == 8'd0) begin
                    left_next = (data_byte & LEN_MASK) + 8'd1;
                    run_next  = data_byte[7];
                    bir_next  = 2'd0;
                    held_next = 24'd0;
                end else if (({1'b0, bir_e} + 3'd1) >= pb) begin
                    a_valid = 1'b1;
                    if (cfg.compressed) begin
                        if (run_reg) begin
                            len       = (29'(left_reg) < remaining) ? left_reg
                                                                    : remaining[7:0];
                            left_next = 8'd0;
                        end else begin
                            left_next = left_reg - 8'd1;
                        end
                    end
                    bir_next  = 2'd0;
                    held_next = 24'd0;
                    if (29'(len) >= remaining) begin
                        last       = 1'b1;
                        phase_next = PH_DONE;
                        left_next  = 8'd0;
                        run_next   = 1'b0;
                    end
                    done_next = done_reg + 29'(len);
                end else begin
                    held_next = rec[23:0];
                    bir_next  = bir_e + 2'd1;
                end
            end
            default: begin
            end
        endcase

        b_valid    = stream_end && (phase_next != PH_DONE);
        stat_first = done_next[27:0];

        if (stream_end) begin
            phase_next = PH_PALETTE;
            fill_next  = 9'd0;
            bir_next   = 2'd0;
            held_next  = 24'd0;
            left_next  = 8'd0;
            run_next   = 1'b0;
            done_next  = 29'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_PALETTE;
            fill_reg      <= '0;
            bir_reg       <= '0;
            held_reg      <= '0;
            left_reg      <= '0;
            run_reg       <= 1'b0;
            done_reg      <= '0;
            p_a_valid_reg <= 1'b0;
            p_b_valid_reg <= 1'b0;
        end else begin
            p_a_valid_reg <= s_accept && a_valid;
            p_b_valid_reg <= s_accept && b_valid;
            if (s_accept) begin
                phase_reg <= phase_next;
                fill_reg  <= fill_next;
                bir_reg   <= bir_next;
                held_reg  <= held_next;
                left_reg  <= left_next;
                run_reg   <= run_next;
                done_reg  <= done_next;
            end
        end
    end

    assign wr_addr_ext = 17'(fill_reg);
    assign rd_addr_ext = 17'(idx);

    always_ff @(posedge aclk) begin
        if (s_accept && pal_we) begin
            pal_mem[wr_addr_ext[AW-1:0]] <= pal_wdata;
        end
        if (s_accept) begin
            pal_q_reg <= pal_mem[rd_addr_ext[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_color_reg      <= dec;
            p_len_reg        <= len;
            p_first_reg      <= done_reg[27:0];
            p_last_reg       <= last;
            p_use_pal_reg    <= cfg.color_mapped;
            p_hit_reg        <= hit;
            p_stat_first_reg <= stat_first;
        end
    end

    always_comb begin
        color_a = p_use_pal_reg ? (p_hit_reg ? pal_q_reg : BLACK) : p_color_reg;
        pix_item  = '{color_argb: color_a, run_length: p_len_reg,
                      first_pixel: p_first_reg, image_last: p_last_reg,
                      truncated: 1'b0};
        stat_item = '{color_argb: 32'd0, run_length: 8'd0,
                      first_pixel: p_stat_first_reg, image_last: 1'b1,
                      truncated: 1'b1};
        if (p_a_valid_reg) begin
            item_a       = pix_item;
            item_b       = stat_item;
            push.a_valid = 1'b1;
            push.b_valid = p_b_valid_reg;
        end else begin
            item_a       = stat_item;
            item_b       = stat_item;
            push.a_valid = p_b_valid_reg;
            push.b_valid = 1'b0;
        end
        pend_n = {1'b0, p_a_valid_reg} + {1'b0, p_b_valid_reg};
    end

    `TPD_ASSERT_HOLDS(a_end_clears, s_accept && stream_end |=> phase_reg == PH_PALETTE && done_reg == '0 && fill_reg == '0, "stream end left image state")
    `TPD_ASSERT_NEVER(a_pixel_len, p_a_valid_reg && p_len_reg == 8'd0, "pixel beat with zero run")

endmodule
